[rtl/gfp_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types for the gyro frame parser.
// No dependencies; every other file refers to it by scoped names.
package gfp_pkg;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int RAW_W    = 16;
	localparam int SCALED_W = 19;
	localparam int POS_W    = 3;

	// Fixed-point format of the scaled value
	localparam int FRACTION_BITS  = 7;
	localparam int RAW_SPAN_SHIFT = 15;

	// Full-scale multipliers (unsigned), product and shift widths
	localparam int FULL_W  = 12;
	localparam int PROD_W  = RAW_W + FULL_W + 1;
	localparam int SHIFT_W = PROD_W + FRACTION_BITS;

	localparam logic [FULL_W-1:0] RATE_FULL  = FULL_W'(2000);
	localparam logic [FULL_W-1:0] ANGLE_FULL = FULL_W'(180);

	// Saturation limits of the 19-bit signed result
	localparam logic signed [SHIFT_W-1:0] OUT_MAX = SHIFT_W'((2 ** (SCALED_W - 1)) - 1);
	localparam logic signed [SHIFT_W-1:0] OUT_MIN = -SHIFT_W'(2 ** (SCALED_W - 1));

	// Frame bytes
	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h5A;
	localparam logic [BYTE_W-1:0] CMD_RATE  = 8'hAA;
	localparam logic [BYTE_W-1:0] CMD_ANGLE = 8'hBB;

	// Byte position within a frame
	localparam logic [POS_W-1:0] POS_HUNT = 3'd0;
	localparam logic [POS_W-1:0] POS_SUM  = 3'd4;

	typedef enum logic {
		KIND_RATE  = 1'b0,
		KIND_ANGLE = 1'b1
	} frame_kind_t;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

[rtl/gfp_if.sv]
`timescale 1ns / 1ps
// Valid/ready channels of the gyro frame parser: received bytes in, decoded frames out.
// Depends on gfp_pkg for field widths.
interface gfp_rx_if;
	logic                         valid;
	logic                         ready;
	logic [gfp_pkg::BYTE_W-1:0]   rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface gfp_result_if;
	logic                                valid;
	logic                                ready;
	logic                                frame_kind;
	logic signed [gfp_pkg::RAW_W-1:0]    raw_value;
	logic signed [gfp_pkg::SCALED_W-1:0] scaled_value;

	modport source (output valid, output frame_kind, output raw_value, output scaled_value,
		input ready);
	modport sink   (input valid, input frame_kind, input raw_value, input scaled_value,
		output ready);
endinterface

[rtl/gyro_frame_parser_core.sv]
`timescale 1ns / 1ps
// Gyro frame parser top level: sync hunt, checksum check, command decode, scaling.
// Depends on gfp_pkg and the channel interfaces in gfp_if.sv.

// Takes one received byte per beat on rx and emits one beat on result for every
// 5-byte frame (0x5A, cmd, data_lo, data_hi, sum) whose 8-bit checksum matches and
// whose cmd is 0xAA (rate, kind 0) or 0xBB (angle, kind 1). Bad frames are dropped
// silently and the parser goes back to hunting for 0x5A; a 0x5A inside a frame is
// plain data. A byte is accepted every cycle unless a result stalls on result.ready; a result becomes
// valid once the checksum byte has passed the input register and then the result
// register. scaled_value holds degrees/s or degrees with 7 fraction bits, rounded toward
// minus infinity. While a result waits for result.ready, one more byte is accepted only
// if the input register is empty; after that rx.ready drops until the result is taken.
module gyro_frame_parser_core (
	input  logic                clk,
	input  logic                arst_n,
	gfp_rx_if.sink              rx,
	gfp_result_if.source        result
);

	// Input register
	logic                  valid_s1;
	gfp_pkg::byte_t        byte_s1;

	// Parser state
	logic [gfp_pkg::POS_W-1:0] pos_q;
	gfp_pkg::byte_t            frame_q [1:3];

	// Result register
	logic                                  out_valid_q;
	gfp_pkg::frame_kind_t                  kind_q;
	logic signed [gfp_pkg::RAW_W-1:0]      raw_q;
	logic signed [gfp_pkg::SCALED_W-1:0]   scaled_q;

	logic                                  advance;
	logic                                  step;
	logic                                  hit;
	gfp_pkg::byte_t                        sum;
	logic                                  cmd_ok;
	gfp_pkg::frame_kind_t                  kind;
	logic [gfp_pkg::FULL_W-1:0]            full;
	logic signed [gfp_pkg::RAW_W-1:0]      raw;
	logic signed [gfp_pkg::PROD_W-1:0]     prod;
	logic signed [gfp_pkg::SHIFT_W-1:0]    wide;
	logic signed [gfp_pkg::SHIFT_W-1:0]    floored;
	logic signed [gfp_pkg::SHIFT_W-1:0]    sat;

	assign advance  = !out_valid_q || result.ready;
	assign rx.ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// Frame decode
	assign sum = gfp_pkg::BYTE_W'(gfp_pkg::SYNC_BYTE + frame_q[1] + frame_q[2] + frame_q[3]);
	assign raw = {frame_q[3], frame_q[2]};

	always_comb begin
		cmd_ok = 1'b1;
		kind   = gfp_pkg::KIND_RATE;
		full   = gfp_pkg::RATE_FULL;
		priority if (frame_q[1] == gfp_pkg::CMD_RATE) begin
			kind = gfp_pkg::KIND_RATE;
			full = gfp_pkg::RATE_FULL;
		end else if (frame_q[1] == gfp_pkg::CMD_ANGLE) begin
			kind = gfp_pkg::KIND_ANGLE;
			full = gfp_pkg::ANGLE_FULL;
		end else begin
			cmd_ok = 1'b0;
		end
	end

	assign hit = step && (pos_q == gfp_pkg::POS_SUM) && (sum == byte_s1) && cmd_ok;

	// raw * full * 2^F / 2^15, floor via arithmetic shift, then saturate
	assign prod    = gfp_pkg::PROD_W'(raw) * $signed({1'b0, full});
	assign wide    = gfp_pkg::SHIFT_W'(prod) <<< gfp_pkg::FRACTION_BITS;
	assign floored = wide >>> gfp_pkg::RAW_SPAN_SHIFT;

	always_comb begin
		priority if (floored > gfp_pkg::OUT_MAX) begin
			sat = gfp_pkg::OUT_MAX;
		end else if (floored < gfp_pkg::OUT_MIN) begin
			sat = gfp_pkg::OUT_MIN;
		end else begin
			sat = floored;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= gfp_pkg::POS_HUNT;
		end else if (step) begin
			priority if (pos_q == gfp_pkg::POS_HUNT || pos_q > gfp_pkg::POS_SUM) begin
				pos_q <= (byte_s1 == gfp_pkg::SYNC_BYTE) ? gfp_pkg::POS_W'(1)
					: gfp_pkg::POS_HUNT;
			end else if (pos_q < gfp_pkg::POS_SUM) begin
				pos_q <= pos_q + gfp_pkg::POS_W'(1);
			end else begin
				pos_q <= gfp_pkg::POS_HUNT;
			end
		end
	end

	// Sync byte is implied by position, only cmd/lo/hi are kept
	always_ff @(posedge clk) begin
		if (step && pos_q != gfp_pkg::POS_HUNT && pos_q < gfp_pkg::POS_SUM) begin
			frame_q[pos_q[1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (hit) begin
			out_valid_q <= 1'b1;
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hit) begin
			kind_q   <= kind;
			raw_q    <= raw;
			scaled_q <= sat[gfp_pkg::SCALED_W-1:0];
		end
	end

	assign result.valid        = out_valid_q;
	assign result.frame_kind   = kind_q;
	assign result.raw_value    = raw_q;
	assign result.scaled_value = scaled_q;

	// Checks
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= gfp_pkg::POS_SUM)
		else $error("byte position out of range");

	a_hunt_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(step && pos_q == gfp_pkg::POS_HUNT && byte_s1 != gfp_pkg::SYNC_BYTE)
		|=> pos_q == gfp_pkg::POS_HUNT)
		else $error("non-sync byte left hunt state");

	a_new_result_after_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(pos_q) == gfp_pkg::POS_SUM)
		else $error("result not caused by checksum byte");

	a_sign_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (scaled_q[gfp_pkg::SCALED_W-1] == raw_q[gfp_pkg::RAW_W-1]))
		else $error("scaled value sign differs from raw value");

	a_angle_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == gfp_pkg::KIND_ANGLE)
		|-> (scaled_q <= 19'sd23040 && scaled_q >= -19'sd23040))
		else $error("angle result beyond full scale");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for gyro_frame_parser_core: byte stream in, decoded frames out.
// Depends on gfp_pkg, gfp_if.sv (channel interfaces) and the parser RTL.
module tb;

	localparam int RATE_SCALE  = 2000;
	localparam int ANGLE_SCALE = 180;
	localparam int PHASE_BYTES = 88;

	typedef struct {
		gfp_pkg::frame_kind_t                 kind;
		logic signed [gfp_pkg::RAW_W-1:0]     raw;
		logic signed [gfp_pkg::SCALED_W-1:0]  scaled;
	} gyro_reading_t;

	typedef struct {
		gfp_pkg::byte_t b;
		bit             typed;
		gyro_reading_t  r;
	} stim_row_t;

	logic clk;
	logic arst_n;

	gfp_rx_if     rx_ch();
	gfp_result_if res_ch();

	gyro_frame_parser_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.result (res_ch)
	);

	// predictor state
	logic [gfp_pkg::POS_W-1:0] frame_pos;
	gfp_pkg::byte_t            frame_buf [4];

	gyro_reading_t readings_due [$];
	int            errors;
	int            bytes_sent;
	int            send_idle_pct;
	int            recv_stall_pct;
	bit            hold_req;
	int            hold_left;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// floor(raw * full * 2^FRACTION_BITS / 2^15), clamped to the output width
	function automatic logic signed [gfp_pkg::SCALED_W-1:0] to_fixed(
		input logic signed [gfp_pkg::RAW_W-1:0] raw, input int full);
		longint p;
		longint hi;
		hi = (longint'(1) << (gfp_pkg::SCALED_W - 1)) - 1;
		p = longint'(raw) * full * (longint'(1) << gfp_pkg::FRACTION_BITS);
		p = p >>> gfp_pkg::RAW_SPAN_SHIFT;
		if (p > hi) p = hi;
		if (p < -hi - 1) p = -hi - 1;
		return p[gfp_pkg::SCALED_W-1:0];
	endfunction

	function automatic bit decode_byte(input gfp_pkg::byte_t b, output gyro_reading_t r);
		gfp_pkg::byte_t sum;
		r = '{gfp_pkg::KIND_RATE, '0, '0};
		if (frame_pos == gfp_pkg::POS_HUNT || frame_pos > gfp_pkg::POS_SUM) begin
			frame_pos = gfp_pkg::POS_HUNT;
			if (b == gfp_pkg::SYNC_BYTE) begin
				frame_buf[0] = b;
				frame_pos = 3'd1;
			end
			return 1'b0;
		end
		if (frame_pos < gfp_pkg::POS_SUM) begin
			frame_buf[frame_pos[1:0]] = b;
			frame_pos = frame_pos + 3'd1;
			return 1'b0;
		end
		frame_pos = gfp_pkg::POS_HUNT;
		sum = frame_buf[0] + frame_buf[1] + frame_buf[2] + frame_buf[3];
		if (sum != b)
			return 1'b0;
		r.raw = {frame_buf[3], frame_buf[2]};
		if (frame_buf[1] == gfp_pkg::CMD_RATE) begin
			r.kind = gfp_pkg::KIND_RATE;
			r.scaled = to_fixed(r.raw, RATE_SCALE);
		end else if (frame_buf[1] == gfp_pkg::CMD_ANGLE) begin
			r.kind = gfp_pkg::KIND_ANGLE;
			r.scaled = to_fixed(r.raw, ANGLE_SCALE);
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// Offers one byte, waits for the beat, then queues the row's own reading if typed, else what the frame decodes to.
	// valid is left high; the next call or drop_valid decides what follows.
	task automatic send_byte(input gfp_pkg::byte_t b, input bit typed,
		input gyro_reading_t tr);
		bit            acc;
		bit            got;
		gyro_reading_t r;
		if ($urandom_range(99) < send_idle_pct) begin
			rx_ch.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		do begin
			@(negedge clk);
			acc = rx_ch.ready;
			@(posedge clk);
		end while (!acc);
		bytes_sent++;
		got = decode_byte(b, r);
		if (typed)
			readings_due.push_back(tr);
		else if (got)
			readings_due.push_back(r);
	endtask

	task automatic drop_valid();
		rx_ch.valid <= 1'b0;
	endtask

	// always lets one edge pass, so valid is never driven twice in one step
	task automatic wait_results_done();
		drop_valid();
		do
			@(posedge clk);
		while (readings_due.size() != 0);
	endtask

	// Mostly well-formed frames with random content; some bad sums, odd commands,
	// truncated frames and line noise; a clean frame is always a well-formed rate frame.
	task automatic send_random_frame(input bit clean);
		gfp_pkg::byte_t fb [5];
		logic [15:0]    raw;
		int             sel;
		int             n;
		gyro_reading_t  none;
		none = '{gfp_pkg::KIND_RATE, '0, '0};
		if (!clean && $urandom_range(99) < 15) begin
			n = $urandom_range(3, 1);
			repeat (n) send_byte(gfp_pkg::byte_t'($urandom_range(255)), 1'b0, none);
		end
		sel = $urandom_range(99);
		if (clean || sel < 42)
			fb[1] = gfp_pkg::CMD_RATE;
		else if (sel < 84)
			fb[1] = gfp_pkg::CMD_ANGLE;
		else
			fb[1] = gfp_pkg::byte_t'($urandom_range(255));
		case ($urandom_range(7))
			0: raw = 16'h7FFF;
			1: raw = 16'h8000;
			2: raw = 16'hFFFF;
			3: raw = 16'h0000;
			default: raw = 16'($urandom_range(16'hFFFF));
		endcase
		fb[0] = gfp_pkg::SYNC_BYTE;
		fb[2] = raw[7:0];
		fb[3] = raw[15:8];
		fb[4] = fb[0] + fb[1] + fb[2] + fb[3];
		if (!clean && $urandom_range(99) < 10)
			fb[4] = fb[4] ^ gfp_pkg::byte_t'($urandom_range(255, 1));
		n = 5;
		if (!clean && $urandom_range(99) < 5)
			n = $urandom_range(4, 1);
		for (int i = 0; i < n; i++)
			send_byte(fb[i], 1'b0, none);
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 60;
			res_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// a beat seen at the falling edge is taken at the next rising edge
	always @(negedge clk) begin
		gyro_reading_t exp_r;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (readings_due.size() == 0) begin
				$error("unexpected result: kind %0d raw %0d scaled %0d",
					res_ch.frame_kind, res_ch.raw_value, res_ch.scaled_value);
				errors++;
			end else begin
				exp_r = readings_due.pop_front();
				if (res_ch.frame_kind !== exp_r.kind) begin
					$error("frame_kind: expected %0d, got %0d", exp_r.kind, res_ch.frame_kind);
					errors++;
				end
				if (res_ch.raw_value !== exp_r.raw) begin
					$error("raw_value: expected %0d, got %0d", exp_r.raw, res_ch.raw_value);
					errors++;
				end
				if (res_ch.scaled_value !== exp_r.scaled) begin
					$error("scaled_value: expected %0d, got %0d", exp_r.scaled,
						res_ch.scaled_value);
					errors++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		stim_row_t     directed_rows [$];
		gyro_reading_t none;
		none = '{gfp_pkg::KIND_RATE, '0, '0};
		errors = 0;
		bytes_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		frame_pos = gfp_pkg::POS_HUNT;
		foreach (frame_buf[i]) frame_buf[i] = '0;
		arst_n <= 1'b0;
		rx_ch.valid <= 1'b0;
		rx_ch.rx_byte <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// noise while hunting
		directed_rows.push_back('{8'h00, 1'b0, none});
		directed_rows.push_back('{8'hFF, 1'b0, none});
		// rate, largest positive raw
		directed_rows.push_back('{gfp_pkg::SYNC_BYTE, 1'b0, none});
		directed_rows.push_back('{gfp_pkg::CMD_RATE, 1'b0, none});
		directed_rows.push_back('{8'hFF, 1'b0, none});
		directed_rows.push_back('{8'h7F, 1'b0, none});
		directed_rows.push_back('{8'h82, 1'b1,
			'{gfp_pkg::KIND_RATE, 16'sh7FFF, 19'sd255992}});
		// angle, most negative raw
		directed_rows.push_back('{gfp_pkg::SYNC_BYTE, 1'b0, none});
		directed_rows.push_back('{gfp_pkg::CMD_ANGLE, 1'b0, none});
		directed_rows.push_back('{8'h00, 1'b0, none});
		directed_rows.push_back('{8'h80, 1'b0, none});
		directed_rows.push_back('{8'h95, 1'b1,
			'{gfp_pkg::KIND_ANGLE, 16'sh8000, -19'sd23040}});
		// bad checksum: dropped
		directed_rows.push_back('{gfp_pkg::SYNC_BYTE, 1'b0, none});
		directed_rows.push_back('{gfp_pkg::CMD_RATE, 1'b0, none});
		directed_rows.push_back('{8'h00, 1'b0, none});
		directed_rows.push_back('{8'h00, 1'b0, none});
		directed_rows.push_back('{8'h05, 1'b0, none});
		// unknown command, good sum, sync byte as payload: dropped
		directed_rows.push_back('{gfp_pkg::SYNC_BYTE, 1'b0, none});
		directed_rows.push_back('{8'h00, 1'b0, none});
		directed_rows.push_back('{gfp_pkg::SYNC_BYTE, 1'b0, none});
		directed_rows.push_back('{8'h00, 1'b0, none});
		directed_rows.push_back('{8'hB4, 1'b0, none});
		// rate, raw -1: floors to -8
		directed_rows.push_back('{gfp_pkg::SYNC_BYTE, 1'b0, none});
		directed_rows.push_back('{gfp_pkg::CMD_RATE, 1'b0, none});
		directed_rows.push_back('{8'hFF, 1'b0, none});
		directed_rows.push_back('{8'hFF, 1'b0, none});
		directed_rows.push_back('{8'h02, 1'b1, '{gfp_pkg::KIND_RATE, -16'sd1, -19'sd8}});
		foreach (directed_rows[i])
			send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].r);
		wait_results_done();

		// long hold-off on the result side while frames keep coming
		hold_req = 1'b1;
		repeat (4) send_random_frame(1'b1);
		wait_results_done();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			bytes_sent = 0;
			while (bytes_sent < PHASE_BYTES)
				send_random_frame(1'b0);
			wait_results_done();
		end

		// trailing cycles catch any stray result
		repeat (20) @(posedge clk);
		if (errors == 0 && readings_due.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

[gyro_frame_parser_core.f]
rtl/gfp_pkg.sv
rtl/gfp_if.sv
rtl/gyro_frame_parser_core.sv
bench/tb.sv
